/* rtl/ols_pkg.sv */
// Shared constants, types and codes for the ordered list store.
package ols_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int POS_W      = 5;
  localparam int CNT_W      = 5;
  localparam int IDX_W      = $clog2(CAPACITY);

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [2:0] {
    FN_INSERT = 3'd0,
    FN_ERASE  = 3'd1,
    FN_READ   = 3'd2,
    FN_WRITE  = 3'd3,
    FN_SEARCH = 3'd4,
    FN_CLEAR  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_ERASE  = 2'd2,
    CMD_WRITE  = 2'd3
  } cmd_t;

  // Broadcast from the control to every cell of the chain.
  typedef struct packed {
    cmd_t             cmd;
    logic [POS_W-1:0] pos;
    word_t            word;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

endpackage

/* rtl/ols_if.sv */
// Valid/ready channel interfaces for the ordered list store.
interface ols_in_if;
  logic                     valid;
  logic                     ready;
  logic [2:0]               func;
  logic [ols_pkg::POS_W-1:0] position;
  logic signed [31:0]       value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface ols_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic signed [31:0]        read_value;
  logic                      found;
  logic [ols_pkg::CNT_W-1:0] count;
  logic [ols_pkg::POS_W-1:0] result_position;

  modport source (output valid, output status, output read_value, output found,
                  output count, output result_position, input ready);
  modport sink   (input valid, input status, input read_value, input found,
                  input count, input result_position, output ready);
endinterface

/* rtl/ols_cell.sv */
// One storage cell of the list chain: holds one element, shifts with its neighbours.
module ols_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  ols_pkg::cell_ctrl_t ctrl,
  input  ols_pkg::word_t      lower_data,
  input  ols_pkg::word_t      upper_data,
  output ols_pkg::word_t      data,
  output logic                match
);

  localparam logic [ols_pkg::POS_W-1:0] MY_POS = ols_pkg::POS_W'(IDX);
  localparam logic [ols_pkg::CNT_W-1:0] MY_CNT = ols_pkg::CNT_W'(IDX);

  ols_pkg::word_t data_r;
  ols_pkg::word_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (ctrl.cmd)
      ols_pkg::CMD_INSERT: begin
        // take the lower neighbour above the slot, the new word at it
        if (MY_POS > ctrl.pos) data_nxt = lower_data;
        else if (MY_POS == ctrl.pos) data_nxt = ctrl.word;
      end
      ols_pkg::CMD_ERASE: begin
        if (MY_POS >= ctrl.pos) data_nxt = upper_data;
      end
      ols_pkg::CMD_WRITE: begin
        if (MY_POS == ctrl.pos) data_nxt = ctrl.word;
      end
      ols_pkg::CMD_HOLD: data_nxt = data_r;
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (MY_CNT < ctrl.count) && (data_r == ctrl.word);

endmodule

/* rtl/ordered_list_store.sv */
// Top level of the ordered list store: control, cell chain and result register.
//
// A fixed-capacity ordered list of signed 32-bit words, kept packed from position 0 up to
// the count. Each transaction on the input channel carries one operation (insert, erase,
// read, write, search, clear) and gives exactly one result transaction. The list lives in
// a chain of identical cells, one element per cell; insert and erase move every affected
// element to its neighbouring cell in the same clock, search compares in every cell at
// once, and read selects the addressed cell. So a new transaction can be accepted each
// clock, and its result appears in the output register on the following clock. The input
// is stalled only while a finished result waits and the output side is not ready. Capacity
// is 16 elements; out-of-range positions, inserts into a full list and erases from an empty
// list leave the list unchanged and return an error status. Storage cells need no clearing
// after reset: the count starts at zero and only positions below it are ever read or
// searched.
module ordered_list_store (
  input  logic         clk,
  input  logic         rst_n,
  ols_in_if.sink       in_chan,
  ols_out_if.source    out_chan
);

  localparam int CAP = ols_pkg::CAPACITY;

  logic                      accept;
  logic [ols_pkg::CNT_W-1:0] cnt_r;
  logic [ols_pkg::CNT_W-1:0] cnt_nxt;
  logic [ols_pkg::POS_W-1:0] pos;
  ols_pkg::word_t            word;
  ols_pkg::cell_ctrl_t       ctrl;
  ols_pkg::cmd_t             cmd;

  ols_pkg::word_t            cell_data [CAP];
  logic [CAP-1:0]            cell_match;

  // result register
  logic                      out_valid_r;
  ols_pkg::status_t          status_r,  status_nxt;
  ols_pkg::word_t            rd_r,      rd_nxt;
  logic                      found_r,   found_nxt;
  logic [ols_pkg::CNT_W-1:0] ocnt_r;
  logic [ols_pkg::POS_W-1:0] rpos_r,    rpos_nxt;

  // accept whenever the result register is free or being drained
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign pos  = in_chan.position;
  assign word = ols_pkg::word_t'(in_chan.value);

  // decode the operation, check ranges, pick the chain command
  always_comb begin
    status_nxt = ols_pkg::ST_OK;
    rd_nxt     = '0;
    found_nxt  = 1'b0;
    rpos_nxt   = '0;
    cnt_nxt    = cnt_r;
    cmd        = ols_pkg::CMD_HOLD;
    unique case (in_chan.func)
      ols_pkg::FN_INSERT: begin
        if (ols_pkg::CNT_W'(pos) > cnt_r) begin
          status_nxt = ols_pkg::ST_RANGE;
        end else if (cnt_r == ols_pkg::CNT_W'(CAP)) begin
          status_nxt = ols_pkg::ST_FULL;
        end else begin
          cmd      = ols_pkg::CMD_INSERT;
          cnt_nxt  = cnt_r + 1'b1;
          rpos_nxt = pos;
        end
      end
      ols_pkg::FN_ERASE: begin
        if (cnt_r == '0) begin
          status_nxt = ols_pkg::ST_EMPTY;
        end else if (ols_pkg::CNT_W'(pos) >= cnt_r) begin
          status_nxt = ols_pkg::ST_RANGE;
        end else begin
          cmd      = ols_pkg::CMD_ERASE;
          cnt_nxt  = cnt_r - 1'b1;
          rpos_nxt = pos;
        end
      end
      ols_pkg::FN_READ: begin
        if (ols_pkg::CNT_W'(pos) >= cnt_r) status_nxt = ols_pkg::ST_RANGE;
        else rd_nxt = cell_data[pos[ols_pkg::IDX_W-1:0]];
      end
      ols_pkg::FN_WRITE: begin
        if (ols_pkg::CNT_W'(pos) >= cnt_r) status_nxt = ols_pkg::ST_RANGE;
        else cmd = ols_pkg::CMD_WRITE;
      end
      ols_pkg::FN_SEARCH: begin
        found_nxt = |cell_match;
      end
      ols_pkg::FN_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        // unused selector: no change, ok status
      end
    endcase
  end

  always_comb begin
    ctrl.cmd   = accept ? cmd : ols_pkg::CMD_HOLD;
    ctrl.pos   = pos;
    ctrl.word  = word;
    ctrl.count = cnt_r;
  end

  // chain of cells; the first cell takes the new word from below, the last feeds back its own data above
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    ols_pkg::word_t lower_d;
    ols_pkg::word_t upper_d;
    if (i == 0) begin : g_first
      assign lower_d = word;
    end else begin : g_mid_lo
      assign lower_d = cell_data[i-1];
    end
    if (i == CAP - 1) begin : g_last
      assign upper_d = cell_data[i];
    end else begin : g_mid_hi
      assign upper_d = cell_data[i+1];
    end
    ols_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .lower_data (lower_d),
      .upper_data (upper_d),
      .data       (cell_data[i]),
      .match      (cell_match[i])
    );
  end

  // element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  // result valid: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, held until the next accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      rd_r     <= rd_nxt;
      found_r  <= found_nxt;
      ocnt_r   <= cnt_nxt;
      rpos_r   <= rpos_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = status_r;
  assign out_chan.read_value      = 32'(signed'(rd_r));
  assign out_chan.found           = found_r;
  assign out_chan.count           = ocnt_r;
  assign out_chan.result_position = rpos_r;

endmodule

/* verif/list_result_checker.sv */
// Result checker for the ordered list store: predicts every result and compares it on arrival.
module list_result_checker
  import ols_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [2:0]       in_func,
  input  logic [POS_W-1:0] in_position,
  input  logic [31:0]      in_value,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [1:0]       out_status,
  input  logic [31:0]      out_read_value,
  input  logic             out_found,
  input  logic [CNT_W-1:0] out_count,
  input  logic [POS_W-1:0] out_result_position,
  output int               mismatches,
  output int               awaiting,
  output int               stored_len
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t          status;
    word_t            read_value;
    logic             found;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] result_position;
  } list_result_t;

  // Shadow copy of the list contents and length.
  word_t        shadow_words [CAPACITY];
  int           shadow_len = 0;
  int           err_total  = 0;
  list_result_t pending_results [$];

  function automatic list_result_t apply_list_op(input logic [2:0] fn,
                                                 input logic [POS_W-1:0] pos,
                                                 input word_t word);
    list_result_t r;
    int p;
    r.status          = ST_OK;
    r.read_value      = '0;
    r.found           = 1'b0;
    r.count           = '0;
    r.result_position = '0;
    p = int'(pos);
    case (fn)
      FN_INSERT: begin
        if (p > shadow_len) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_len; i > p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p] = word;
          shadow_len++;
          r.result_position = pos;
        end
      end
      FN_ERASE: begin
        // an empty list wins over a bad position
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
          r.result_position = pos;
        end
      end
      FN_READ: begin
        if (p >= shadow_len) r.status = ST_RANGE;
        else r.read_value = shadow_words[p];
      end
      FN_WRITE: begin
        if (p >= shadow_len) r.status = ST_RANGE;
        else shadow_words[p] = word;
      end
      FN_SEARCH: begin
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_words[i] == word) r.found = 1'b1;
        end
      end
      FN_CLEAR: shadow_len = 0;
      default: ;
    endcase
    r.count = CNT_W'(shadow_len);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n) begin
      // queue the prediction first so the oldest entry is always the one to match
      if (in_valid && in_ready) begin
        pending_results = {pending_results, apply_list_op(in_func, in_position, in_value)};
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          err_total++;
          if (err_total <= 10) begin
            $display("%0t: result with nothing outstanding: status=%0d read_value=%08h",
                     $realtime, out_status, out_read_value);
          end
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status || out_read_value !== want.read_value ||
              out_found !== want.found || out_count !== want.count ||
              out_result_position !== want.result_position) begin
            err_total++;
            if (err_total <= 10) begin
              $display({"%0t: mismatch: expected status=%0d read_value=%08h found=%0b ",
                        "count=%0d position=%0d, got status=%0d read_value=%08h found=%0b ",
                        "count=%0d position=%0d"},
                       $realtime, want.status, want.read_value, want.found, want.count,
                       want.result_position, out_status, out_read_value, out_found,
                       out_count, out_result_position);
            end
          end
        end
      end
    end
    mismatches <= err_total;
    awaiting   <= pending_results.size();
    stored_len <= shadow_len;
  end

endmodule

/* verif/tb_ordered_list_store.sv */
// Testbench top for the ordered list store: clock, reset, stimulus and the verdict.
module tb_ordered_list_store;
  import ols_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Selector codes the block leaves unused; they must act as no-ops.
  localparam logic [2:0] FN_SPARE_LO = 3'd6;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  localparam word_t WORD_MAX = 32'h7FFF_FFFF;
  localparam word_t WORD_MIN = 32'h8000_0000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Drive every block input to a known value from time zero.
  logic             in_valid    = 1'b0;
  logic [2:0]       in_func     = '0;
  logic [POS_W-1:0] in_position = '0;
  word_t            in_value    = '0;
  logic             out_ready   = 1'b0;

  // Percentage of cycles the sender idles and the receiver stalls.
  int idle_pct  = 0;
  int stall_pct = 0;

  int mismatches;
  int awaiting;
  int stored_len;

  // Recently stored words, reused so that searches actually hit.
  word_t recent_words [8];
  int    recent_slot = 0;
  bit    draining    = 1'b0;

  ols_in_if  in_ch ();
  ols_out_if out_ch ();

  assign in_ch.valid    = in_valid;
  assign in_ch.func     = in_func;
  assign in_ch.position = in_position;
  assign in_ch.value    = in_value;
  assign out_ch.ready   = out_ready;

  ordered_list_store DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch.sink),
    .out_chan (out_ch.source)
  );

  list_result_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_ch.valid),
    .in_ready            (in_ch.ready),
    .in_func             (in_ch.func),
    .in_position         (in_ch.position),
    .in_value            (in_ch.value),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_status          (out_ch.status),
    .out_read_value      (out_ch.read_value),
    .out_found           (out_ch.found),
    .out_count           (out_ch.count),
    .out_result_position (out_ch.result_position),
    .mismatches          (mismatches),
    .awaiting            (awaiting),
    .stored_len          (stored_len)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: drop ready on a random share of cycles set by the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one transaction, idling first at random, and hold it until it is taken.
  // Signals sampled just after the edge still carry their pre-edge values, since
  // everything here and in the block changes through nonblocking assignments.
  task automatic issue(input logic [2:0] fn, input logic [POS_W-1:0] pos,
                       input word_t word);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= fn;
    in_position <= pos;
    in_value    <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Word payloads lean on the extremes and on words already stored.
  function automatic word_t pick_word();
    case ($urandom_range(9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return '1;
      4, 5:    return recent_words[$urandom_range(7)];
      default: return word_t'($urandom);
    endcase
  endfunction

  // One random transaction. The list is steered between filling up and draining,
  // so full and empty lists both come round often; positions stay mostly in range,
  // with the boundary and the whole 5-bit field mixed in. The length seen here may
  // trail by one transaction, which only blurs the steering.
  task automatic issue_random();
    int               r;
    int               len;
    int               hi;
    int               ins_w;
    int               era_w;
    int               clr_w;
    logic [2:0]       fn;
    logic [POS_W-1:0] pos;
    word_t            word;
    len = stored_len;
    if (len >= CAPACITY && $urandom_range(2) == 0) draining = 1'b1;
    else if (len == 0) draining = 1'b0;
    ins_w = draining ? 12 : 48;
    era_w = draining ? 48 : 12;
    clr_w = draining ? 3 : 1;

    r = $urandom_range(99);
    if (r < ins_w) fn = FN_INSERT;
    else if (r < ins_w + era_w) fn = FN_ERASE;
    else if (r < ins_w + era_w + 12) fn = FN_READ;
    else if (r < ins_w + era_w + 22) fn = FN_WRITE;
    else if (r < ins_w + era_w + 36) fn = FN_SEARCH;
    else if (r < ins_w + era_w + 36 + clr_w) fn = FN_CLEAR;
    else fn = $urandom_range(1) ? FN_SPARE_HI : FN_SPARE_LO;

    hi = (fn == FN_INSERT) ? len : len - 1;
    r  = $urandom_range(9);
    if (r == 0) pos = POS_W'($urandom_range(31));
    else if (r == 1 || hi < 0) pos = POS_W'(len);
    else pos = POS_W'($urandom_range(hi));

    word = pick_word();
    if (fn == FN_SEARCH && $urandom_range(4) < 3) word = recent_words[$urandom_range(7)];
    if (fn == FN_INSERT || fn == FN_WRITE) begin
      recent_words[recent_slot] = word;
      recent_slot = (recent_slot + 1) % 8;
    end
    issue(fn, pos, word);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) recent_words[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening, no idling. Empty list first: erase reports empty even with
    // a wild position, read and write are out of range, insert past the end too.
    issue(FN_ERASE,  5'd0,  '0);
    issue(FN_ERASE,  5'd31, '0);
    issue(FN_READ,   5'd0,  '0);
    issue(FN_WRITE,  5'd0,  32'd5);
    issue(FN_INSERT, 5'd1,  32'd7);
    issue(FN_SEARCH, 5'd0,  '0);

    // Fill to capacity, mixing front, middle and end inserts with extreme words.
    for (int i = 0; i < CAPACITY; i++) begin
      case (i)
        0:       issue(FN_INSERT, 5'd0, WORD_MAX);
        1:       issue(FN_INSERT, 5'd1, WORD_MIN);
        2:       issue(FN_INSERT, 5'd1, '1);
        3:       issue(FN_INSERT, 5'd0, '0);
        default: issue(FN_INSERT, POS_W'((i % 3 == 0) ? 0 : (i % 3 == 1) ? i : i / 2),
                       word_t'($urandom));
      endcase
    end

    // Full list: a valid position reports full, a position past the end is a range error.
    issue(FN_INSERT, 5'd16, 32'd1);
    issue(FN_INSERT, 5'd0,  32'd1);
    issue(FN_INSERT, 5'd17, 32'd1);
    issue(FN_READ,   5'd15, '0);
    issue(FN_READ,   5'd16, '0);
    issue(FN_WRITE,  5'd15, WORD_MIN);
    issue(FN_SEARCH, 5'd31, WORD_MIN);
    issue(FN_ERASE,  5'd16, '0);
    issue(FN_ERASE,  5'd15, '0);
    issue(FN_ERASE,  5'd0,  '0);
    issue(FN_SPARE_LO, 5'd3, WORD_MAX);
    issue(FN_SPARE_HI, 5'd31, '1);
    issue(FN_CLEAR,  5'd0,  '0);
    issue(FN_READ,   5'd0,  '0);

    // Random phases: free flow, sender gaps, receiver stalls, then both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 48; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 48; end
        default: begin idle_pct = 29; stall_pct <= 29; end
      endcase
      repeat (150) issue_random();
    end
    in_valid <= 1'b0;
    // let the checker count the last accepted transaction
    @(posedge clk);

    // Drain the outstanding results, then wait on to catch strays.
    while (awaiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && awaiting == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
